FILE: design/slide_to_arm_controller_defines.svh
// assertion macros for the slide-to-arm controller
// used by the top level; expects clk and arst_n in scope
`ifndef SLIDE_TO_ARM_CONTROLLER_DEFINES_SVH
`define SLIDE_TO_ARM_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define STAC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stac assertion failed");

// next-cycle implication, checked out of reset
`define STAC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stac assertion failed");

`endif

FILE: design/stac_pkg.sv
// types and constants for the slide-to-arm controller
// no dependencies
`timescale 1ns / 1ps

package stac_pkg;

	localparam int unsigned COL_W  = 8;
	localparam int unsigned ROW_W  = 9;
	localparam int unsigned AGE_W  = 13;
	localparam int unsigned CIDX_W = 3;
	localparam int unsigned CDAT_W = 13;

	localparam logic [AGE_W-1:0] AGE_MAX = 13'd8191;

	typedef enum logic [2:0] {
		CMD_RELEASE   = 3'd0,
		CMD_TOUCH     = 3'd1,
		CMD_HEARTBEAT = 3'd2,
		CMD_MESSAGE   = 3'd3,
		CMD_TICK      = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REQ_NONE   = 2'd0,
		REQ_ARM    = 2'd1,
		REQ_DISARM = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		PEND_IDLE      = 2'd0,
		PEND_ARMING    = 2'd1,
		PEND_DISARMING = 2'd2
	} pend_t;

	typedef enum logic [2:0] {
		CFG_ARM_START     = 3'd0,
		CFG_DISARM_START  = 3'd1,
		CFG_ARM_TRIGGER   = 3'd2,
		CFG_DISARM_TRIGGER = 3'd3,
		CFG_STRIP_TOP     = 3'd4,
		CFG_CONFIRM_TO    = 3'd5,
		CFG_LINK_TO       = 3'd6
	} cfg_idx_t;

	localparam logic [COL_W-1:0] RST_ARM_START      = 8'd62;
	localparam logic [COL_W-1:0] RST_DISARM_START   = 8'd178;
	localparam logic [COL_W-1:0] RST_ARM_TRIGGER    = 8'd158;
	localparam logic [COL_W-1:0] RST_DISARM_TRIGGER = 8'd81;
	localparam logic [ROW_W-1:0] RST_STRIP_TOP      = 9'd280;
	localparam logic [AGE_W-1:0] RST_CONFIRM_TO     = 13'd4000;
	localparam logic [AGE_W-1:0] RST_LINK_TO        = 13'd1000;

	typedef struct packed {
		logic [COL_W-1:0] arm_start_limit;
		logic [COL_W-1:0] disarm_start_limit;
		logic [COL_W-1:0] arm_trigger_column;
		logic [COL_W-1:0] disarm_trigger_column;
		logic [ROW_W-1:0] strip_top_row;
		logic [AGE_W-1:0] confirm_timeout_ms;
		logic [AGE_W-1:0] link_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]       command;
		logic [COL_W-1:0] touch_x;
		logic [ROW_W-1:0] touch_y;
		logic             reported_armed;
	} item_t;

	typedef struct packed {
		logic [1:0]       request;
		logic             armed_now;
		logic [1:0]       pending_kind;
		logic             gesture_active;
		logic [COL_W-1:0] thumb_column;
		logic             link_alive;
	} result_t;

endpackage

FILE: design/stac_cfg.sv
// configuration register file of the slide-to-arm controller
// depends on stac_pkg
`timescale 1ns / 1ps

module stac_cfg import stac_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CIDX_W-1:0] wr_index,
	input  logic [CDAT_W-1:0] wr_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_start_limit       <= RST_ARM_START;
			cfg_q.disarm_start_limit    <= RST_DISARM_START;
			cfg_q.arm_trigger_column    <= RST_ARM_TRIGGER;
			cfg_q.disarm_trigger_column <= RST_DISARM_TRIGGER;
			cfg_q.strip_top_row         <= RST_STRIP_TOP;
			cfg_q.confirm_timeout_ms    <= RST_CONFIRM_TO;
			cfg_q.link_timeout_ms       <= RST_LINK_TO;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_ARM_START:      cfg_q.arm_start_limit       <= wr_data[COL_W-1:0];
				CFG_DISARM_START:   cfg_q.disarm_start_limit    <= wr_data[COL_W-1:0];
				CFG_ARM_TRIGGER:    cfg_q.arm_trigger_column    <= wr_data[COL_W-1:0];
				CFG_DISARM_TRIGGER: cfg_q.disarm_trigger_column <= wr_data[COL_W-1:0];
				CFG_STRIP_TOP:      cfg_q.strip_top_row         <= wr_data[ROW_W-1:0];
				CFG_CONFIRM_TO:     cfg_q.confirm_timeout_ms    <= wr_data[AGE_W-1:0];
				CFG_LINK_TO:        cfg_q.link_timeout_ms       <= wr_data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/stac_core.sv
// controller state and its combinational next-state and result logic
// depends on stac_pkg
`timescale 1ns / 1ps

module stac_core import stac_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic             armed_q,  armed_n;
	pend_t            pend_q,   pend_n;
	logic [AGE_W-1:0] page_q,   page_n;
	logic [AGE_W-1:0] mage_q,   mage_n;
	logic             sv_q,     sv_n;
	logic [COL_W-1:0] start_q,  start_n;
	logic [COL_W-1:0] slide_q,  slide_n;
	req_t             req;

	always_comb begin
		armed_n = armed_q;
		pend_n  = pend_q;
		page_n  = page_q;
		mage_n  = mage_q;
		sv_n    = sv_q;
		start_n = start_q;
		slide_n = slide_q;
		req     = REQ_NONE;
		case (cmd_t'(item.command))
			CMD_RELEASE: begin
				sv_n    = 1'b0;
				start_n = '0;
				slide_n = '0;
			end
			CMD_TOUCH: begin
				if (item.touch_y < cfg.strip_top_row) begin
					sv_n    = 1'b0;
					start_n = '0;
					slide_n = '0;
				end else begin
					if (!sv_q && ((!armed_q && item.touch_x <= cfg.arm_start_limit) ||
						(armed_q && item.touch_x >= cfg.disarm_start_limit))) begin
						sv_n    = 1'b1;
						start_n = item.touch_x;
					end
					if (sv_n) begin
						slide_n = item.touch_x;
						// start zone is rechecked against the current limits
						if (!armed_q && start_n <= cfg.arm_start_limit &&
							item.touch_x >= cfg.arm_trigger_column) begin
							req     = REQ_ARM;
							pend_n  = PEND_ARMING;
							page_n  = '0;
							sv_n    = 1'b0;
							start_n = '0;
							slide_n = '0;
						end else if (armed_q && start_n >= cfg.disarm_start_limit &&
							item.touch_x <= cfg.disarm_trigger_column) begin
							req     = REQ_DISARM;
							pend_n  = PEND_DISARMING;
							page_n  = '0;
							sv_n    = 1'b0;
							start_n = '0;
							slide_n = '0;
						end
					end
				end
			end
			CMD_HEARTBEAT: begin
				mage_n = '0;
				if ((pend_q == PEND_ARMING && item.reported_armed) ||
					(pend_q == PEND_DISARMING && !item.reported_armed)) begin
					pend_n = PEND_IDLE;
				end
				armed_n = item.reported_armed;
			end
			CMD_MESSAGE: begin
				mage_n = '0;
			end
			CMD_TICK: begin
				mage_n = (mage_q == AGE_MAX) ? AGE_MAX : mage_q + 1'b1;
				page_n = (page_q == AGE_MAX) ? AGE_MAX : page_q + 1'b1;
				if (pend_q != PEND_IDLE && page_n > cfg.confirm_timeout_ms) begin
					pend_n = PEND_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			pend_q  <= PEND_IDLE;
			page_q  <= '0;
			mage_q  <= '0;
			sv_q    <= 1'b0;
			start_q <= '0;
			slide_q <= '0;
		end else if (step) begin
			armed_q <= armed_n;
			pend_q  <= pend_n;
			page_q  <= page_n;
			mage_q  <= mage_n;
			sv_q    <= sv_n;
			start_q <= start_n;
			slide_q <= slide_n;
		end
	end

	always_comb begin
		result.request        = req;
		result.armed_now      = armed_n;
		result.pending_kind   = pend_n;
		result.gesture_active = sv_n;
		result.thumb_column   = sv_n ? slide_n : '0;
		result.link_alive     = (mage_n <= cfg.link_timeout_ms);
	end

endmodule

FILE: design/slide_to_arm_controller.sv
// slide-to-arm controller top level: input register, core, result register
// depends on stac_pkg, stac_cfg, stac_core and slide_to_arm_controller_defines.svh
//
// channel   direction  payload
// s_axis    in         tuser: command; tdata: touch_x, touch_y, reported_armed
// m_axis    out        tuser: request; tdata: status fields
// cfg       in         cfg_index, cfg_data register write
//
// one event per cycle unless m_axis stalls; path: input register, then result register
// the state update happens in the cycle that moves an event from the input
// register into the result register, so back-to-back events chain through the state
// a stalled result register holds the input register, which then backpressures s_axis
// arst_n clears state and both valid flags and resets configuration; cfg_ready is always high
`timescale 1ns / 1ps
`include "slide_to_arm_controller_defines.svh"

module slide_to_arm_controller import stac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // touch_x[7:0], touch_y[16:8], reported_armed[17], zero
	input  logic [2:0]  s_axis_tuser,  // command[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // armed_now[0], pending_kind[2:1], gesture_active[3],
	                                   // thumb_column[11:4], link_alive[12], zero
	output logic [1:0]  m_axis_tuser,  // request[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CDAT_W-1:0] cfg_data
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res;
	cfg_t    cfg;
	logic    advance;

	assign cfg_ready = 1'b1;

	stac_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// result slot free or draining this cycle
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.command        <= s_axis_tuser;
			item_s1.touch_x        <= s_axis_tdata[7:0];
			item_s1.touch_y        <= s_axis_tdata[16:8];
			item_s1.reported_armed <= s_axis_tdata[17];
		end
	end

	stac_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.request;
	assign m_axis_tdata  = {3'b000, res_s2.link_alive, res_s2.thumb_column,
		res_s2.gesture_active, res_s2.pending_kind, res_s2.armed_now};

	// a fresh request always leaves the block pending on that request
	`STAC_ASSERT_IMPL(a_req_sets_pending, m_axis_tvalid && m_axis_tuser != REQ_NONE,
		m_axis_tdata[2:1] == m_axis_tuser && !m_axis_tdata[3])
	// thumb column reads zero outside a gesture
	`STAC_ASSERT_IMPL(a_thumb_idle, m_axis_tvalid && !m_axis_tdata[3], m_axis_tdata[11:4] == 8'd0)
	// a held input item is not dropped while the result side stalls
	`STAC_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(item_s1))

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for slide_to_arm_controller: stream driver, result monitor and
// a per-event predictor of the gesture, pending and link state, run over several settings
// depends on stac_pkg and the slide_to_arm_controller top level
`timescale 1ns / 1ps

module tb_top;
	import stac_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned PRINT_LIMIT = 100;
	localparam int unsigned PHASE_ITEMS = 250;
	localparam int unsigned SETTLE     = 4;

	// command codes the block ignores, and a register index that does not exist
	localparam logic [2:0]        CMD_SPARE_A = 3'd5;
	localparam logic [2:0]        CMD_SPARE_B = 3'd6;
	localparam logic [2:0]        CMD_SPARE_C = 3'd7;
	localparam logic [CIDX_W-1:0] CFG_SPARE   = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [23:0]       s_axis_tdata = '0;  // touch_x[7:0], touch_y[16:8], reported_armed[17]
	logic [2:0]        s_axis_tuser = '0;  // command[2:0]
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [15:0]       m_axis_tdata;       // armed_now[0], pending_kind[2:1], gesture_active[3],
	                                       // thumb_column[11:4], link_alive[12]
	logic [1:0]        m_axis_tuser;       // request[1:0]
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CDAT_W-1:0] cfg_data = '0;

	slide_to_arm_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predicted controller state and register copy
	cfg_t             regs;
	logic             armed;
	pend_t            pend;
	logic [AGE_W-1:0] pend_age;
	logic [AGE_W-1:0] msg_age;
	logic             slide_on;
	logic [COL_W-1:0] start_col;
	logic [COL_W-1:0] slide_col;

	item_t       events_todo[$];
	result_t     status_due[$];
	item_t       held_event = '0;
	int unsigned queued = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned src_gap = 0;
	int unsigned sink_gap = 0;
	int unsigned src_pct = 0;
	int unsigned sink_pct = 0;

	task automatic report_fault(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at result %0d: %s", results_seen, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] seen, input logic [7:0] want);
		if (seen !== want)
			report_fault($sformatf("%s is %0d, expected %0d", name, seen, want));
	endtask

	task automatic drop_gesture();
		slide_on = 1'b0;
		start_col = '0;
		slide_col = '0;
	endtask

	// advance the predicted state by one event and return the status it produces
	task automatic step_controller(input item_t ev, output result_t r);
		r = '0;
		r.request = REQ_NONE;
		case (ev.command)
			CMD_RELEASE: drop_gesture();
			CMD_TOUCH: begin
				if (ev.touch_y < regs.strip_top_row) begin
					drop_gesture();
				end else begin
					if (!slide_on && ((!armed && ev.touch_x <= regs.arm_start_limit) ||
					                  (armed && ev.touch_x >= regs.disarm_start_limit))) begin
						slide_on = 1'b1;
						start_col = ev.touch_x;
					end
					if (slide_on) begin
						slide_col = ev.touch_x;
						// start zone is checked again with the current armed state
						if (!armed && start_col <= regs.arm_start_limit &&
						    ev.touch_x >= regs.arm_trigger_column) begin
							r.request = REQ_ARM;
							pend = PEND_ARMING;
							pend_age = '0;
							drop_gesture();
						end else if (armed && start_col >= regs.disarm_start_limit &&
						             ev.touch_x <= regs.disarm_trigger_column) begin
							r.request = REQ_DISARM;
							pend = PEND_DISARMING;
							pend_age = '0;
							drop_gesture();
						end
					end
				end
			end
			CMD_HEARTBEAT: begin
				msg_age = '0;
				if ((pend == PEND_ARMING && ev.reported_armed) ||
				    (pend == PEND_DISARMING && !ev.reported_armed))
					pend = PEND_IDLE;
				armed = ev.reported_armed;
			end
			CMD_MESSAGE: msg_age = '0;
			CMD_TICK: begin
				if (msg_age != AGE_MAX)
					msg_age++;
				if (pend_age != AGE_MAX)
					pend_age++;
				if (pend != PEND_IDLE && pend_age > regs.confirm_timeout_ms)
					pend = PEND_IDLE;
			end
			default: ;
		endcase
		r.armed_now = armed;
		r.pending_kind = pend;
		r.gesture_active = slide_on;
		r.thumb_column = slide_on ? slide_col : '0;
		r.link_alive = (msg_age <= regs.link_timeout_ms);
	endtask

	// input driver: predicts each event at the edge where its transaction completes
	always @(posedge clk) begin : feed
		result_t due;
		logic    show;
		show = s_axis_tvalid;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				step_controller(held_event, due);
				status_due.push_back(due);
				show = 1'b0;
			end
			if (!show) begin
				if (src_gap != 0) begin
					src_gap--;
				end else if (events_todo.size() != 0) begin
					if (src_pct != 0 && $urandom_range(99, 0) < src_pct) begin
						src_gap = $urandom_range(4, 0);
					end else begin
						held_event = events_todo.pop_front();
						show = 1'b1;
					end
				end
			end
		end
		s_axis_tvalid <= show;
		s_axis_tdata  <= {6'b0, held_event.reported_armed, held_event.touch_y, held_event.touch_x};
		s_axis_tuser  <= held_event.command;
	end

	// result monitor with random backpressure
	always @(posedge clk) begin : watch
		result_t got;
		result_t want;
		logic    take;
		take = 1'b0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got.request = m_axis_tuser;
				got.armed_now = m_axis_tdata[0];
				got.pending_kind = m_axis_tdata[2:1];
				got.gesture_active = m_axis_tdata[3];
				got.thumb_column = m_axis_tdata[11:4];
				got.link_alive = m_axis_tdata[12];
				if (status_due.size() == 0) begin
					report_fault("result transaction with nothing expected");
				end else begin
					want = status_due.pop_front();
					check_field("request", got.request, want.request);
					check_field("armed_now", got.armed_now, want.armed_now);
					check_field("pending_kind", got.pending_kind, want.pending_kind);
					check_field("gesture_active", got.gesture_active, want.gesture_active);
					check_field("thumb_column", got.thumb_column, want.thumb_column);
					check_field("link_alive", got.link_alive, want.link_alive);
				end
			end
			if (sink_gap != 0)
				sink_gap--;
			else if (sink_pct != 0 && $urandom_range(99, 0) < sink_pct)
				sink_gap = $urandom_range(4, 0);
			else
				take = 1'b1;
		end
		m_axis_tready <= take;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	task automatic push_event(input logic [2:0] cmd, input logic [7:0] x, input logic [8:0] y,
	                          input logic rep);
		item_t ev;
		ev.command = cmd;
		ev.touch_x = x;
		ev.touch_y = y;
		ev.reported_armed = rep;
		events_todo.push_back(ev);
		queued++;
	endtask

	task automatic queue_ticks(input int unsigned n);
		repeat (n)
			push_event(CMD_TICK, $urandom_range(255, 0), $urandom_range(511, 0),
			           $urandom_range(1, 0));
	endtask

	function automatic int unsigned col_top(input int unsigned v);
		return (v > 239) ? 255 : 239;
	endfunction

	// one slide gesture toward arm or disarm, with stray events mixed in
	task automatic queue_slide(input logic disarm_dir);
		int          steps;
		int          k;
		int          first;
		int          goal;
		int          spot;
		int unsigned pick;
		int unsigned row_top;
		bit          reach;
		reach = ($urandom_range(3, 0) != 0);
		steps = $urandom_range(4, 1);
		row_top = (regs.strip_top_row > 319) ? 511 : 319;
		if ($urandom_range(4, 0) != 0)
			push_event(CMD_HEARTBEAT, $urandom_range(255, 0), $urandom_range(511, 0), disarm_dir);
		if (!disarm_dir) begin
			first = $urandom_range(regs.arm_start_limit, 0);
			goal = reach ? $urandom_range(col_top(regs.arm_trigger_column), regs.arm_trigger_column)
			             : $urandom_range(255, 0);
		end else begin
			first = $urandom_range(col_top(regs.disarm_start_limit), regs.disarm_start_limit);
			goal = reach ? $urandom_range(regs.disarm_trigger_column, 0) : $urandom_range(255, 0);
		end
		for (k = 0; k <= steps; k++) begin
			spot = first + (goal - first) * k / steps;
			pick = $urandom_range(19, 0);
			if (pick == 0)
				queue_ticks(1);
			else if (pick == 1)
				push_event(CMD_MESSAGE, $urandom_range(255, 0), $urandom_range(511, 0),
				           $urandom_range(1, 0));
			else if (pick == 2 && regs.strip_top_row != 0)
				push_event(CMD_TOUCH, spot, $urandom_range(regs.strip_top_row - 1, 0),
				           $urandom_range(1, 0));
			push_event(CMD_TOUCH, spot, $urandom_range(row_top, regs.strip_top_row),
			           $urandom_range(1, 0));
		end
		if (!reach && $urandom_range(1, 0))
			push_event(CMD_RELEASE, $urandom_range(255, 0), $urandom_range(511, 0),
			           $urandom_range(1, 0));
	endtask

	task automatic queue_random(input int unsigned count);
		int unsigned stop;
		int unsigned pick;
		int unsigned span;
		logic        dir;
		stop = queued + count;
		span = (regs.confirm_timeout_ms < 45) ? regs.confirm_timeout_ms + 4 : 12;
		while (queued < stop) begin
			pick = $urandom_range(99, 0);
			if (pick < 50) begin
				dir = $urandom_range(1, 0);
				queue_slide(dir);
				pick = $urandom_range(9, 0);
				if (pick < 4)
					push_event(CMD_HEARTBEAT, $urandom_range(255, 0), $urandom_range(511, 0), !dir);
				else if (pick < 7)
					queue_ticks($urandom_range(span, 1));
			end else if (pick < 70) begin
				queue_ticks($urandom_range(span, 1));
			end else if (pick < 80) begin
				push_event(CMD_HEARTBEAT, $urandom_range(255, 0), $urandom_range(511, 0),
				           $urandom_range(1, 0));
			end else if (pick < 86) begin
				push_event(CMD_MESSAGE, $urandom_range(255, 0), $urandom_range(511, 0),
				           $urandom_range(1, 0));
			end else if (pick < 90) begin
				push_event(CMD_RELEASE, $urandom_range(255, 0), $urandom_range(511, 0),
				           $urandom_range(1, 0));
			end else begin
				push_event($urandom_range(7, 0), $urandom_range(255, 0), $urandom_range(511, 0),
				           $urandom_range(1, 0));
			end
		end
	endtask

	// register write; cfg_valid stays high so writes can go back to back
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		case (idx)
			CFG_ARM_START:      regs.arm_start_limit = val[COL_W-1:0];
			CFG_DISARM_START:   regs.disarm_start_limit = val[COL_W-1:0];
			CFG_ARM_TRIGGER:    regs.arm_trigger_column = val[COL_W-1:0];
			CFG_DISARM_TRIGGER: regs.disarm_trigger_column = val[COL_W-1:0];
			CFG_STRIP_TOP:      regs.strip_top_row = val[ROW_W-1:0];
			CFG_CONFIRM_TO:     regs.confirm_timeout_ms = val;
			CFG_LINK_TO:        regs.link_timeout_ms = val;
			default: ;
		endcase
	endtask

	task automatic setup_phase(input int unsigned p);
		logic [CDAT_W-1:0] v [7];
		v[0] = $urandom_range(239, 0);
		v[1] = $urandom_range(239, 0);
		v[2] = $urandom_range(239, 0);
		v[3] = $urandom_range(239, 0);
		v[4] = $urandom_range(319, 0);
		v[5] = $urandom_range(200, 1);
		v[6] = $urandom_range(200, 1);
		case (p)
			0: v = '{0, 0, 0, 0, 0, 1, 1};
			1: v = '{239, 239, 239, 239, 319, 8000, 8000};
			2: begin
				v[5] = $urandom_range(40, 1);
				v[6] = $urandom_range(40, 1);
			end
			3: v = '{RST_ARM_START, RST_DISARM_START, RST_ARM_TRIGGER, RST_DISARM_TRIGGER,
			         RST_STRIP_TOP, $urandom_range(60, 2), $urandom_range(60, 2)};
			4: foreach (v[i]) v[i] = $urandom_range(8191, 0);  // upper bits beyond the column and row registers
			5: begin
				v[5] = 0;
				v[6] = 0;
			end
			default: ;
		endcase
		write_reg(CFG_ARM_START, v[0]);
		write_reg(CFG_DISARM_START, v[1]);
		write_reg(CFG_ARM_TRIGGER, v[2]);
		write_reg(CFG_DISARM_TRIGGER, v[3]);
		write_reg(CFG_STRIP_TOP, v[4]);
		write_reg(CFG_CONFIRM_TO, v[5]);
		write_reg(CFG_LINK_TO, v[6]);
		if (p == 6)
			write_reg(CFG_SPARE, $urandom_range(8191, 0));
		cfg_valid <= 1'b0;
	endtask

	// every queued event yields one result, so the block is empty once all have come back
	task automatic drain();
		while (results_seen < queued)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_directed();
		push_event(CMD_SPARE_A, 8'd0, 9'd0, 1'b0);
		push_event(CMD_SPARE_B, 8'd100, 9'd300, 1'b0);
		push_event(CMD_SPARE_C, 8'd255, 9'd511, 1'b1);
		push_event(CMD_TOUCH, 8'd0, 9'd280, 1'b0);       // arming starts at the far left
		push_event(CMD_TOUCH, 8'd100, 9'd300, 1'b0);
		push_event(CMD_TOUCH, 8'd100, 9'd279, 1'b0);     // leaves the strip
		push_event(CMD_TOUCH, 8'd62, 9'd319, 1'b0);
		push_event(CMD_RELEASE, 8'd0, 9'd0, 1'b0);
		push_event(CMD_TOUCH, 8'd63, 9'd300, 1'b0);      // just outside the start zone
		push_event(CMD_TOUCH, 8'd62, 9'd300, 1'b0);
		push_event(CMD_TOUCH, 8'd158, 9'd300, 1'b0);     // arm fires
		push_event(CMD_TOUCH, 8'd30, 9'd290, 1'b0);
		push_event(CMD_TOUCH, 8'd239, 9'd319, 1'b0);     // fires again while pending
		push_event(CMD_HEARTBEAT, 8'd0, 9'd0, 1'b1);     // confirms arming
		push_event(CMD_TOUCH, 8'd177, 9'd300, 1'b0);
		push_event(CMD_TOUCH, 8'd178, 9'd300, 1'b0);     // disarming starts
		push_event(CMD_HEARTBEAT, 8'd0, 9'd0, 1'b0);     // armed state flips mid-gesture
		push_event(CMD_TOUCH, 8'd50, 9'd300, 1'b0);
		push_event(CMD_HEARTBEAT, 8'd0, 9'd0, 1'b1);
		push_event(CMD_TOUCH, 8'd81, 9'd300, 1'b0);      // disarm fires
		push_event(CMD_MESSAGE, 8'd255, 9'd511, 1'b1);
		push_event(CMD_TICK, 8'd255, 9'd511, 1'b1);
		push_event(CMD_HEARTBEAT, 8'd0, 9'd0, 1'b1);     // does not confirm disarming
		push_event(CMD_TICK, 8'd0, 9'd0, 1'b0);
		push_event(CMD_HEARTBEAT, 8'd255, 9'd511, 1'b0); // confirms disarming
	endtask

	initial begin : run
		regs = '{RST_ARM_START, RST_DISARM_START, RST_ARM_TRIGGER, RST_DISARM_TRIGGER,
		         RST_STRIP_TOP, RST_CONFIRM_TO, RST_LINK_TO};
		armed = 1'b0;
		pend = PEND_IDLE;
		pend_age = '0;
		msg_age = '0;
		drop_gesture();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_pct = 15;
		sink_pct = 15;
		queue_directed();
		drain();
		for (int p = 0; p < 7; p++) begin
			setup_phase(p);
			src_pct = 15 * $urandom_range(3, 0);
			sink_pct = 15 * $urandom_range(3, 0);
			queue_random(PHASE_ITEMS);
			drain();
		end

		// no more idling from here on
		src_pct = 0;
		sink_pct = 0;

		// both ages run into saturation; full-scale timeouts never expire
		write_reg(CFG_ARM_START, RST_ARM_START);
		write_reg(CFG_DISARM_START, RST_DISARM_START);
		write_reg(CFG_ARM_TRIGGER, RST_ARM_TRIGGER);
		write_reg(CFG_DISARM_TRIGGER, RST_DISARM_TRIGGER);
		write_reg(CFG_STRIP_TOP, RST_STRIP_TOP);
		write_reg(CFG_CONFIRM_TO, AGE_MAX);
		write_reg(CFG_LINK_TO, AGE_MAX);
		cfg_valid <= 1'b0;
		push_event(CMD_HEARTBEAT, 8'd0, 9'd0, 1'b0);
		push_event(CMD_TOUCH, 8'd10, 9'd300, 1'b0);
		push_event(CMD_TOUCH, 8'd200, 9'd300, 1'b0);
		queue_ticks(AGE_MAX + 10);
		drain();
		write_reg(CFG_CONFIRM_TO, 8000);
		write_reg(CFG_LINK_TO, AGE_MAX - 1);
		cfg_valid <= 1'b0;
		queue_ticks(2);
		push_event(CMD_MESSAGE, 8'd0, 9'd0, 1'b0);
		queue_ticks(1);
		push_event(CMD_HEARTBEAT, 8'd0, 9'd0, 1'b1);
		drain();

		setup_phase(7);
		queue_random(PHASE_ITEMS);
		drain();

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: slide_to_arm_controller.f
+incdir+design
design/stac_pkg.sv
design/stac_cfg.sv
design/stac_core.sv
design/slide_to_arm_controller.sv
tb/sv/tb_top.sv
